FILE: hw/rtl/rsrd_pkg.sv
// Shared constants, control word layout and microprogram for the session run decoder.
`default_nettype none

package rsrd_pkg;

  localparam int IMAGE_BYTES = 65536;
  localparam int ADDR_W      = $clog2(IMAGE_BYTES);

  // Operation codes
  localparam logic [1:0] OPN_WRITE = 2'd0;
  localparam logic [1:0] OPN_START = 2'd1;
  localparam logic [1:0] OPN_FETCH = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_WRITTEN   = 3'd0;
  localparam logic [2:0] ST_STARTED   = 3'd1;
  localparam logic [2:0] ST_MINUTE    = 3'd2;
  localparam logic [2:0] ST_END_OK    = 3'd3;
  localparam logic [2:0] ST_NO_MARKER = 3'd4;
  localparam logic [2:0] ST_NO_TERM   = 3'd5;
  localparam logic [2:0] ST_IDLE      = 3'd6;

  // Configuration register indexes
  localparam logic [1:0] REG_RING_START  = 2'd0;
  localparam logic [1:0] REG_RING_END    = 2'd1;
  localparam logic [1:0] REG_MAX_MINUTES = 2'd2;

  localparam logic [16:0] RING_END_RST    = 17'h10000;
  localparam logic [15:0] MAX_MINUTES_RST = 16'd1440;

  localparam logic [7:0] MARKER_BYTE = 8'hFE;
  localparam logic [7:0] TERM_BYTE   = 8'hFF;
  localparam logic [7:0] SECONDS_LIM = 8'd60;

  // Remainder unit: one dividend bit per step
  localparam int          DIV_W     = 17;
  localparam logic [4:0]  DIV_STEPS = 5'(DIV_W - 1);

  // Sequencer
  localparam int PC_W = 5;

  typedef enum logic [1:0] {
    NX_NEXT,
    NX_JUMP,
    NX_BRANCH,
    NX_DISPATCH
  } nx_t;

  typedef enum logic [1:0] {
    C_CNT_MORE,
    C_MARK_BAD,
    C_ZERO4,
    C_TERM
  } cond_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_MOD_INIT,
    DP_MOD_STEP,
    DP_MOD_FIX,
    DP_MOD_ADD,
    DP_SAVE,
    DP_RESTORE,
    DP_START_COMMIT,
    DP_FETCH_COMMIT,
    DP_END_RUN
  } dp_op_t;

  typedef struct packed {
    nx_t             nx;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            rd;
    logic            cap;
    logic            emit;
    logic [2:0]      status;
    dp_op_t          op;
  } ctl_t;

  typedef struct packed {
    logic window_ok;
    logic active;
    logic below_max;
    logic cnt_more;
    logic mark_bad;
    logic zero4;
    logic term;
    logic out_busy;
  } flags_t;

  // Program labels
  localparam logic [PC_W-1:0] PC_DISPATCH  = 5'd0;
  localparam logic [PC_W-1:0] PC_START     = 5'd1;
  localparam logic [PC_W-1:0] PC_MOD_LOOP  = 5'd2;
  localparam logic [PC_W-1:0] PC_COMMIT    = 5'd17;
  localparam logic [PC_W-1:0] PC_FETCH     = 5'd18;
  localparam logic [PC_W-1:0] PC_EMIT_WR   = 5'd25;
  localparam logic [PC_W-1:0] PC_EMIT_IDLE = 5'd26;
  localparam logic [PC_W-1:0] PC_NO_MARKER = 5'd27;
  localparam logic [PC_W-1:0] PC_NO_TERM   = 5'd28;
  localparam logic [PC_W-1:0] PC_END_OK    = 5'd29;
  localparam logic [PC_W-1:0] PC_LAST      = 5'd29;

  function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
    ctl_t c;
    c = '{nx: NX_NEXT, cond: C_CNT_MORE, target: PC_DISPATCH, rd: 1'b0, cap: 1'b0,
          emit: 1'b0, status: ST_IDLE, op: DP_NONE};
    case (pc)
      5'd0:  c.nx = NX_DISPATCH;
      // start: fold cursor+2 into the window
      5'd1:  c.op = DP_MOD_INIT;
      5'd2:  begin c.op = DP_MOD_STEP; c.nx = NX_BRANCH; c.cond = C_CNT_MORE;
                   c.target = PC_MOD_LOOP; end
      5'd3:  c.op = DP_MOD_FIX;
      5'd4:  c.op = DP_MOD_ADD;
      // marker bytes
      5'd5:  c.rd = 1'b1;
      5'd6:  begin c.rd = 1'b1; c.cap = 1'b1; end
      5'd7:  begin c.rd = 1'b1; c.cap = 1'b1; end
      5'd8:  begin c.cap = 1'b1; c.op = DP_SAVE; end
      5'd9:  begin c.nx = NX_BRANCH; c.cond = C_MARK_BAD; c.target = PC_NO_MARKER; end
      // optional zero block
      5'd10: c.rd = 1'b1;
      5'd11: begin c.rd = 1'b1; c.cap = 1'b1; end
      5'd12: begin c.rd = 1'b1; c.cap = 1'b1; end
      5'd13: begin c.rd = 1'b1; c.cap = 1'b1; end
      5'd14: c.cap = 1'b1;
      5'd15: begin c.nx = NX_BRANCH; c.cond = C_ZERO4; c.target = PC_COMMIT; end
      5'd16: c.op = DP_RESTORE;
      5'd17: begin c.op = DP_START_COMMIT; c.emit = 1'b1; c.status = ST_STARTED;
                   c.nx = NX_JUMP; end
      // fetch one minute chunk
      5'd18: c.rd = 1'b1;
      5'd19: begin c.rd = 1'b1; c.cap = 1'b1; end
      5'd20: begin c.rd = 1'b1; c.cap = 1'b1; end
      5'd21: begin c.rd = 1'b1; c.cap = 1'b1; end
      5'd22: c.cap = 1'b1;
      5'd23: begin c.nx = NX_BRANCH; c.cond = C_TERM; c.target = PC_END_OK; end
      5'd24: begin c.op = DP_FETCH_COMMIT; c.emit = 1'b1; c.status = ST_MINUTE;
                   c.nx = NX_JUMP; end
      // result-only steps
      5'd25: begin c.emit = 1'b1; c.status = ST_WRITTEN; c.nx = NX_JUMP; end
      5'd26: begin c.emit = 1'b1; c.status = ST_IDLE; c.nx = NX_JUMP; end
      5'd27: begin c.op = DP_END_RUN; c.emit = 1'b1; c.status = ST_NO_MARKER;
                   c.nx = NX_JUMP; end
      5'd28: begin c.op = DP_END_RUN; c.emit = 1'b1; c.status = ST_NO_TERM;
                   c.nx = NX_JUMP; end
      5'd29: begin c.op = DP_END_RUN; c.emit = 1'b1; c.status = ST_END_OK;
                   c.nx = NX_JUMP; end
      default: c.nx = NX_JUMP;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rsrd_seq.sv
// Microcode sequencer: step counter, control store and dispatch on the operation.
`default_nettype none

module rsrd_seq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [1:0]       in_operation,
  input  wire rsrd_pkg::flags_t flags,
  output rsrd_pkg::ctl_t        ctl,
  output logic                  adv
);

  logic [rsrd_pkg::PC_W-1:0] pc_r;
  logic [rsrd_pkg::PC_W-1:0] pc_nxt;
  logic [rsrd_pkg::PC_W-1:0] disp_pc;
  logic                      cond_hit;

  assign ctl       = rsrd_pkg::ucode(pc_r);
  assign in_tready = (pc_r == rsrd_pkg::PC_DISPATCH);
  // hold an emitting step while the result register is still full
  assign adv       = !(ctl.emit && flags.out_busy);

  always_comb begin
    case (in_operation)
      rsrd_pkg::OPN_WRITE: disp_pc = rsrd_pkg::PC_EMIT_WR;
      rsrd_pkg::OPN_START: disp_pc = flags.window_ok ? rsrd_pkg::PC_START
                                                      : rsrd_pkg::PC_NO_MARKER;
      rsrd_pkg::OPN_FETCH: begin
        if (!flags.active)
          disp_pc = rsrd_pkg::PC_EMIT_IDLE;
        else if (flags.window_ok && flags.below_max)
          disp_pc = rsrd_pkg::PC_FETCH;
        else
          disp_pc = rsrd_pkg::PC_NO_TERM;
      end
      default: disp_pc = rsrd_pkg::PC_EMIT_IDLE;
    endcase
  end

  always_comb begin
    case (ctl.cond)
      rsrd_pkg::C_CNT_MORE: cond_hit = flags.cnt_more;
      rsrd_pkg::C_MARK_BAD: cond_hit = flags.mark_bad;
      rsrd_pkg::C_ZERO4:    cond_hit = flags.zero4;
      rsrd_pkg::C_TERM:     cond_hit = flags.term;
      default:              cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt = pc_r;
    if (adv) begin
      case (ctl.nx)
        rsrd_pkg::NX_NEXT:     pc_nxt = pc_r + 5'd1;
        rsrd_pkg::NX_JUMP:     pc_nxt = ctl.target;
        rsrd_pkg::NX_BRANCH:   pc_nxt = cond_hit ? ctl.target : pc_r + 5'd1;
        rsrd_pkg::NX_DISPATCH: pc_nxt = in_tvalid ? disp_pc : pc_r;
        default:               pc_nxt = rsrd_pkg::PC_DISPATCH;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= rsrd_pkg::PC_DISPATCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  a_accept_leaves_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (pc_r != rsrd_pkg::PC_DISPATCH))
    else $error("sequencer stayed in dispatch after a transaction");

  a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r <= rsrd_pkg::PC_LAST))
    else $error("step counter left the program");

endmodule

`default_nettype wire

FILE: hw/rtl/rsrd_dp.sv
// Datapath: image memory, window pointer, remainder unit, run state and result register.
`default_nettype none

module rsrd_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [16:0]         cfg_wdata,
  input  wire logic                in_accept,
  input  wire logic [1:0]          in_operation,
  input  wire logic [15:0]         in_address,
  input  wire logic [7:0]          in_write_data,
  input  wire logic [15:0]         in_cursor,
  input  wire rsrd_pkg::ctl_t      ctl,
  input  wire logic                adv,
  output rsrd_pkg::flags_t         flags,
  input  wire logic                out_tready,
  output logic                     out_tvalid,
  output logic [2:0]               out_status,
  output logic [7:0]               out_pressure_tenths,
  output logic [3:0]               out_apnea_count,
  output logic [3:0]               out_hypopnea_count,
  output logic [3:0]               out_snoring_count,
  output logic [15:0]              out_minute_index
);

  // Configuration
  logic [15:0] ring_start_r;
  logic [16:0] ring_end_r;
  logic [15:0] max_minutes_r;
  logic [16:0] span_r;

  // Run state
  logic [15:0] rdpos_r;
  logic [15:0] md_r;
  logic        active_r;

  // Working registers
  logic [15:0] pos_r;
  logic [15:0] save_r;
  logic [15:0] cur_r;
  logic        neg_r;
  logic [rsrd_pkg::DIV_W-1:0] div_r;
  logic [rsrd_pkg::DIV_W-1:0] rem_r;
  logic [4:0]  cnt_r;
  logic [7:0]  rdata_r;
  logic [7:0]  byte_r [4];

  // Result register
  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [7:0]  out_press_r;
  logic [3:0]  out_apn_r;
  logic [3:0]  out_hyp_r;
  logic [3:0]  out_sno_r;
  logic [15:0] out_idx_r;

  logic [7:0]  mem [rsrd_pkg::IMAGE_BYTES];

  logic [16:0] pos_inc;
  logic [15:0] pos_adv_nxt;
  logic [16:0] cur_plus2;
  logic        cur_below;
  logic [17:0] rem_sh;
  logic        rem_ge;
  logic        minute_ok;

  assign pos_inc     = {1'b0, pos_r} + 17'd1;
  // wrap to the window start when one past the end
  assign pos_adv_nxt = (pos_inc >= ring_end_r) ? ring_start_r : pos_inc[15:0];
  assign cur_plus2   = {1'b0, cur_r} + 17'd2;
  assign cur_below   = cur_plus2 < {1'b0, ring_start_r};
  assign rem_sh      = {rem_r, div_r[rsrd_pkg::DIV_W-1]};
  assign rem_ge      = rem_sh >= {1'b0, span_r};
  assign minute_ok   = byte_r[1] < rsrd_pkg::SECONDS_LIM;

  always_comb begin
    flags.window_ok = ring_end_r > {1'b0, ring_start_r};
    flags.active    = active_r;
    flags.below_max = md_r < max_minutes_r;
    flags.cnt_more  = cnt_r != 5'd0;
    flags.mark_bad  = (byte_r[1] != rsrd_pkg::MARKER_BYTE) ||
                      (byte_r[2] != rsrd_pkg::MARKER_BYTE) ||
                      (byte_r[3] != rsrd_pkg::MARKER_BYTE);
    flags.zero4     = (byte_r[0] == 8'h00) && (byte_r[1] == 8'h00) &&
                      (byte_r[2] == 8'h00) && (byte_r[3] == 8'h00);
    flags.term      = (byte_r[0] == rsrd_pkg::TERM_BYTE) &&
                      (byte_r[1] == rsrd_pkg::TERM_BYTE) &&
                      (byte_r[2] == rsrd_pkg::TERM_BYTE);
    flags.out_busy  = out_valid_r && !out_tready;
  end

  // Image memory: one port, registered read
  always_ff @(posedge clk) begin
    if (in_accept && (in_operation == rsrd_pkg::OPN_WRITE))
      mem[in_address[rsrd_pkg::ADDR_W-1:0]] <= in_write_data;
    else if (adv && ctl.rd)
      rdata_r <= mem[pos_r[rsrd_pkg::ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_start_r  <= '0;
      ring_end_r    <= rsrd_pkg::RING_END_RST;
      max_minutes_r <= rsrd_pkg::MAX_MINUTES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rsrd_pkg::REG_RING_START:  ring_start_r  <= cfg_wdata[15:0];
        rsrd_pkg::REG_RING_END:    ring_end_r    <= cfg_wdata;
        rsrd_pkg::REG_MAX_MINUTES: max_minutes_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    span_r <= ring_end_r - {1'b0, ring_start_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdpos_r  <= '0;
      md_r     <= '0;
      active_r <= 1'b0;
    end else if (adv) begin
      case (ctl.op)
        rsrd_pkg::DP_START_COMMIT: begin
          rdpos_r  <= pos_r;
          md_r     <= '0;
          active_r <= 1'b1;
        end
        rsrd_pkg::DP_FETCH_COMMIT: begin
          rdpos_r <= pos_r;
          md_r    <= md_r + 16'd1;
        end
        rsrd_pkg::DP_END_RUN: active_r <= 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cur_r <= in_cursor;
      pos_r <= rdpos_r;
    end else if (adv) begin
      if (ctl.rd)
        pos_r <= pos_adv_nxt;
      if (ctl.cap) begin
        byte_r[0] <= byte_r[1];
        byte_r[1] <= byte_r[2];
        byte_r[2] <= byte_r[3];
        byte_r[3] <= rdata_r;
      end
      case (ctl.op)
        rsrd_pkg::DP_MOD_INIT: begin
          // fold the distance from the window start, keeping its sign apart
          neg_r <= cur_below;
          div_r <= cur_below ? ({1'b0, ring_start_r} - cur_plus2)
                             : (cur_plus2 - {1'b0, ring_start_r});
          rem_r <= '0;
          cnt_r <= rsrd_pkg::DIV_STEPS;
        end
        rsrd_pkg::DP_MOD_STEP: begin
          rem_r <= rem_ge ? 17'(rem_sh - {1'b0, span_r}) : rem_sh[16:0];
          div_r <= {div_r[rsrd_pkg::DIV_W-2:0], 1'b0};
          cnt_r <= cnt_r - 5'd1;
        end
        rsrd_pkg::DP_MOD_FIX: begin
          if (neg_r && (rem_r != '0))
            rem_r <= span_r - rem_r;
        end
        rsrd_pkg::DP_MOD_ADD: pos_r  <= 16'({1'b0, ring_start_r} + rem_r);
        rsrd_pkg::DP_SAVE:    save_r <= pos_r;
        rsrd_pkg::DP_RESTORE: pos_r  <= save_r;
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && ctl.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctl.emit) begin
      out_status_r <= ctl.status;
      if (ctl.status == rsrd_pkg::ST_MINUTE) begin
        out_press_r <= byte_r[0];
        out_apn_r   <= minute_ok ? byte_r[2][7:4] : 4'd0;
        out_hyp_r   <= minute_ok ? byte_r[2][3:0] : 4'd0;
        out_sno_r   <= minute_ok ? byte_r[3][3:0] : 4'd0;
        out_idx_r   <= md_r;
      end else begin
        out_press_r <= '0;
        out_apn_r   <= '0;
        out_hyp_r   <= '0;
        out_sno_r   <= '0;
        out_idx_r   <= '0;
      end
    end
  end

  assign out_tvalid          = out_valid_r;
  assign out_status          = out_status_r;
  assign out_pressure_tenths = out_press_r;
  assign out_apnea_count     = out_apn_r;
  assign out_hypopnea_count  = out_hyp_r;
  assign out_snoring_count   = out_sno_r;
  assign out_minute_index    = out_idx_r;

  a_minute_count: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (ctl.op == rsrd_pkg::DP_FETCH_COMMIT)) |=> (md_r == $past(md_r) + 16'd1))
    else $error("minute counter did not advance on a minute result");

  a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (ctl.op == rsrd_pkg::DP_MOD_STEP)) |=> (rem_r < span_r))
    else $error("partial remainder not below the window span");

  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != rsrd_pkg::ST_MINUTE)) |->
      ((out_press_r == 8'd0) && (out_apn_r == 4'd0) && (out_hyp_r == 4'd0) &&
       (out_sno_r == 4'd0) && (out_idx_r == 16'd0)))
    else $error("non-minute result carries payload");

endmodule

`default_nettype wire

FILE: hw/rtl/ring_session_run_decoder_top.sv
// Top level of the therapy-log session run decoder: stream ports and field packing.
//
// Input stream (in_*): one transaction is one operation. Write stores a byte of the
// log image, start opens a run at a session cursor, fetch reads the next minute.
// Output stream (out_*): exactly one result transaction per input transaction, in
// order, carrying a status and, for a minute, its pressure, event counts and index.
// Configuration (cfg_*): single-cycle writes of ring_start, ring_end and max_minutes; the
// user must make them only while no operation is in flight, the block does not enforce it.
// Operation flow: a start runs the bit-serial remainder that folds the cursor into the
// window, and the chunk bytes are read one at a time over the single memory port.
// One operation is in flight at a time.
// Reset (rst_n low, synchronous) clears the run, the minute counter and the
// configuration to its defaults; the image memory is not cleared and holds
// whatever was last written.
// When the receiver stalls, the result waits in the output register; the next
// operation is still taken and runs until it needs that register.
`default_nettype none

module ring_session_run_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [16:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // operation[1:0], address[17:2], write_data[25:18], cursor[41:26], zero[47:42]
  input  wire logic [47:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // status[2:0], pressure_tenths[10:3], apnea_count[14:11], hypopnea_count[18:15],
  // snoring_count[22:19], minute_index[38:23], zero[39]
  output logic [39:0]      out_tdata
);

  rsrd_pkg::ctl_t   ctl;
  rsrd_pkg::flags_t flags;
  logic             adv;
  logic             in_accept;

  logic [1:0]  in_operation;
  logic [15:0] in_address;
  logic [7:0]  in_write_data;
  logic [15:0] in_cursor;

  logic [2:0]  out_status;
  logic [7:0]  out_pressure_tenths;
  logic [3:0]  out_apnea_count;
  logic [3:0]  out_hypopnea_count;
  logic [3:0]  out_snoring_count;
  logic [15:0] out_minute_index;

  assign in_operation  = in_tdata[1:0];
  assign in_address    = in_tdata[17:2];
  assign in_write_data = in_tdata[25:18];
  assign in_cursor     = in_tdata[41:26];
  assign in_accept     = in_tvalid && in_tready;

  assign out_tdata = {1'b0, out_minute_index, out_snoring_count, out_hypopnea_count,
                      out_apnea_count, out_pressure_tenths, out_status};

  rsrd_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_operation (in_operation),
    .flags        (flags),
    .ctl          (ctl),
    .adv          (adv)
  );

  rsrd_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_accept           (in_accept),
    .in_operation        (in_operation),
    .in_address          (in_address),
    .in_write_data       (in_write_data),
    .in_cursor           (in_cursor),
    .ctl                 (ctl),
    .adv                 (adv),
    .flags               (flags),
    .out_tready          (out_tready),
    .out_tvalid          (out_tvalid),
    .out_status          (out_status),
    .out_pressure_tenths (out_pressure_tenths),
    .out_apnea_count     (out_apnea_count),
    .out_hypopnea_count  (out_hypopnea_count),
    .out_snoring_count   (out_snoring_count),
    .out_minute_index    (out_minute_index)
  );

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking bench for the session run decoder: directed log runs, then random sessions.

module testbench;

  localparam int CLK_HALF    = 4;
  localparam int SETTLE      = 40;
  localparam int IDLE_LIMIT  = 4000;
  localparam int RANDOM_WORK = 250;
  localparam int HOLD_CYCLES = 300;

  localparam logic [1:0] OPN_SPARE = 2'd3;
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [15:0] minute_index;
    logic [3:0]  snoring_count;
    logic [3:0]  hypopnea_count;
    logic [3:0]  apnea_count;
    logic [7:0]  pressure_tenths;
    logic [2:0]  status;
  } minute_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [16:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  ring_session_run_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Decoder mirror: image, window registers and run state
  logic [7:0] image_copy [rsrd_pkg::IMAGE_BYTES];
  bit         image_known [rsrd_pkg::IMAGE_BYTES];
  int         win_lo = 0;
  int         win_hi = 65536;
  int         minute_cap = 1440;
  int         chunk_pos = 0;
  int         minutes_given = 0;
  bit         run_open = 1'b0;

  minute_result_t expected_results [$];
  int error_count = 0;
  int work_items = 0;

  int tx_burst_left = 0;
  bit tx_steady = 1'b0;
  int rx_hold_left = 0;
  int rx_stall_pct = 0;
  int rx_cycle = 0;
  int idle_cycles = 0;

  function automatic bit window_open();
    return win_hi > win_lo;
  endfunction

  // Offset off advanced by cnt, folded into the window; only with an open window
  function automatic int fold(input int off, input int cnt);
    int span;
    int r;
    span = win_hi - win_lo;
    r = (off + cnt - win_lo) % span;
    if (r < 0) r += span;
    return win_lo + r;
  endfunction

  function automatic logic [7:0] ring_byte(input int pos, input int k);
    return image_copy[fold(pos, k) % rsrd_pkg::IMAGE_BYTES];
  endfunction

  function automatic minute_result_t decode_step(input logic [1:0] op, input logic [15:0] addr,
                                                 input logic [7:0] data, input logic [15:0] cur);
    minute_result_t r;
    int pos;
    logic [7:0] b0, b1, b2, b3;
    r = '0;
    r.status = rsrd_pkg::ST_IDLE;
    case (op)
      rsrd_pkg::OPN_WRITE: begin
        image_copy[addr] = data;
        image_known[addr] = 1'b1;
        r.status = rsrd_pkg::ST_WRITTEN;
      end
      rsrd_pkg::OPN_START: begin
        run_open = 1'b0;
        r.status = rsrd_pkg::ST_NO_MARKER;
        if (window_open()) begin
          pos = fold(int'(cur), 2);
          if (ring_byte(pos, 0) == rsrd_pkg::MARKER_BYTE &&
              ring_byte(pos, 1) == rsrd_pkg::MARKER_BYTE &&
              ring_byte(pos, 2) == rsrd_pkg::MARKER_BYTE) begin
            pos = fold(pos, 3);
            if (ring_byte(pos, 0) == 8'h00 && ring_byte(pos, 1) == 8'h00 &&
                ring_byte(pos, 2) == 8'h00 && ring_byte(pos, 3) == 8'h00)
              pos = fold(pos, 4);
            chunk_pos = pos;
            minutes_given = 0;
            run_open = 1'b1;
            r.status = rsrd_pkg::ST_STARTED;
          end
        end
      end
      rsrd_pkg::OPN_FETCH: begin
        if (run_open) begin
          if (!window_open() || minutes_given >= minute_cap) begin
            run_open = 1'b0;
            r.status = rsrd_pkg::ST_NO_TERM;
          end else begin
            b0 = ring_byte(chunk_pos, 0);
            b1 = ring_byte(chunk_pos, 1);
            b2 = ring_byte(chunk_pos, 2);
            b3 = ring_byte(chunk_pos, 3);
            if (b0 == rsrd_pkg::TERM_BYTE && b1 == rsrd_pkg::TERM_BYTE &&
                b2 == rsrd_pkg::TERM_BYTE) begin
              run_open = 1'b0;
              r.status = rsrd_pkg::ST_END_OK;
            end else begin
              r.status = rsrd_pkg::ST_MINUTE;
              r.pressure_tenths = b0;
              if (b1 < rsrd_pkg::SECONDS_LIM) begin
                r.apnea_count = b2[7:4];
                r.hypopnea_count = b2[3:0];
                r.snoring_count = b3[3:0];
              end
              r.minute_index = 16'(minutes_given);
              minutes_given = (minutes_given + 1) & 16'hFFFF;
              chunk_pos = fold(chunk_pos, 4);
            end
          end
        end
      end
      default: ;
    endcase
    if (r.status != rsrd_pkg::ST_IDLE) work_items++;
    return r;
  endfunction

  // Offer one transaction in the current burst; record its expected result once taken
  task automatic push_op(input logic [1:0] op, input logic [15:0] addr, input logic [7:0] data,
                         input logic [15:0] cur);
    int gap;
    gap = 0;
    if (!tx_steady) begin
      if (tx_burst_left == 0) begin
        tx_burst_left = $urandom_range(1, 16);
        if ($urandom_range(0, 2) != 0) gap = $urandom_range(1, 6);
      end
      tx_burst_left--;
    end
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {6'b0, cur, data, addr, op};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_results.push_back(decode_step(op, addr, data, cur));
  endtask

  task automatic push_write(input int addr, input logic [7:0] data);
    push_op(rsrd_pkg::OPN_WRITE, 16'(addr), data, 16'($urandom));
  endtask

  function automatic logic [7:0] filler_byte();
    case ($urandom_range(0, 4))
      0, 1: return rsrd_pkg::MARKER_BYTE;
      2: return 8'h00;
      3: return rsrd_pkg::TERM_BYTE;
      default: return 8'($urandom);
    endcase
  endfunction

  // Write any byte of the span that the decoder is about to read and that holds nothing yet
  task automatic fill_unknown(input int pos, input int count);
    int k;
    int a;
    for (k = 0; k < count; k++) begin
      a = fold(pos, k) % rsrd_pkg::IMAGE_BYTES;
      if (!image_known[a]) push_write(a, filler_byte());
    end
  endtask

  task automatic push_start(input logic [15:0] cur);
    int pos;
    if (window_open()) begin
      pos = fold(int'(cur), 2);
      fill_unknown(pos, 3);
      if (ring_byte(pos, 0) == rsrd_pkg::MARKER_BYTE &&
          ring_byte(pos, 1) == rsrd_pkg::MARKER_BYTE &&
          ring_byte(pos, 2) == rsrd_pkg::MARKER_BYTE)
        fill_unknown(fold(pos, 3), 4);
    end
    push_op(rsrd_pkg::OPN_START, 16'($urandom), 8'($urandom), cur);
  endtask

  task automatic push_fetch();
    if (run_open && window_open() && minutes_given < minute_cap) fill_unknown(chunk_pos, 4);
    push_op(rsrd_pkg::OPN_FETCH, 16'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task automatic wait_results();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_window(input int lo, input int hi, input int cap);
    wait_results();
    cfg_we    <= 1'b1;
    cfg_index <= rsrd_pkg::REG_RING_START;
    cfg_wdata <= 17'(lo);
    @(posedge clk);
    cfg_index <= rsrd_pkg::REG_RING_END;
    cfg_wdata <= 17'(hi);
    @(posedge clk);
    cfg_index <= rsrd_pkg::REG_MAX_MINUTES;
    cfg_wdata <= 17'(cap);
    @(posedge clk);
    cfg_we <= 1'b0;
    win_lo = lo & 16'hFFFF;
    win_hi = hi & 17'h1FFFF;
    minute_cap = cap & 16'hFFFF;
  endtask

  // Lay down a well-formed log at a random cursor, then start and fetch through it
  task automatic run_session(input int minutes, input bit zero_block, input bit closed);
    logic [15:0] cur;
    logic [7:0] chunk [4];
    int pos;
    int m;
    int k;
    cur = 16'($urandom);
    if (window_open()) begin
      pos = fold(int'(cur), 2);
      for (k = 0; k < 3; k++)
        push_write(fold(pos, k) % rsrd_pkg::IMAGE_BYTES, rsrd_pkg::MARKER_BYTE);
      pos = fold(pos, 3);
      if (zero_block) begin
        for (k = 0; k < 4; k++) push_write(fold(pos, k) % rsrd_pkg::IMAGE_BYTES, 8'h00);
        pos = fold(pos, 4);
      end
      for (m = 0; m < minutes; m++) begin
        chunk[0] = 8'($urandom);
        case ($urandom_range(0, 5))
          0: chunk[1] = rsrd_pkg::SECONDS_LIM - 8'd1;
          1: chunk[1] = rsrd_pkg::SECONDS_LIM;
          2, 3: chunk[1] = 8'($urandom_range(0, 59));
          default: chunk[1] = 8'($urandom);
        endcase
        chunk[2] = 8'($urandom);
        chunk[3] = 8'($urandom);
        if (chunk[0] == rsrd_pkg::TERM_BYTE && chunk[1] == rsrd_pkg::TERM_BYTE &&
            chunk[2] == rsrd_pkg::TERM_BYTE)
          chunk[2] = 8'h00;
        for (k = 0; k < 4; k++) push_write(fold(pos, k) % rsrd_pkg::IMAGE_BYTES, chunk[k]);
        pos = fold(pos, 4);
      end
      if (closed) begin
        for (k = 0; k < 3; k++)
          push_write(fold(pos, k) % rsrd_pkg::IMAGE_BYTES, rsrd_pkg::TERM_BYTE);
        push_write(fold(pos, 3) % rsrd_pkg::IMAGE_BYTES, 8'($urandom));
      end
    end
    push_start(cur);
    repeat (minutes + 1 + $urandom_range(0, 2)) push_fetch();
  endtask

  task automatic pick_window();
    int lo;
    int span;
    int cap;
    span = $urandom_range(8, 160);
    lo = $urandom_range(0, 65536 - span);
    case ($urandom_range(0, 9))
      0: begin lo = 0; span = 65536; end
      1: begin lo = 65535; span = 1; end
      2: begin lo = 0; span = 1; end
      3: begin lo = $urandom_range(40, 65535); span = 0 - int'($urandom_range(0, 40)); end
      default: ;
    endcase
    case ($urandom_range(0, 5))
      0: cap = 1;
      1: cap = 65535;
      2: cap = $urandom_range(2, 6);
      default: cap = 1440;
    endcase
    set_window(lo, lo + span, cap);
  endtask

  task automatic test_image_extremes();
    push_write(0, 8'h00);
    push_write(65535, 8'hFF);
    push_write(16'h5555, 8'hAA);
    push_write(16'hAAAA, 8'h55);
  endtask

  task automatic test_idle_answers();
    push_op(OPN_SPARE, 16'hFFFF, 8'hFF, 16'hFFFF);
    push_fetch();
  endtask

  // Marker wraps at the window end; zero block, a minute, a late-seconds minute, terminator
  task automatic test_marker_and_minutes();
    int k;
    set_window(16, 48, 1440);
    for (k = 45; k < 48; k++) push_write(k, rsrd_pkg::MARKER_BYTE);
    for (k = 16; k < 20; k++) push_write(k, 8'h00);
    push_write(20, 8'hFF); push_write(21, 8'h3B); push_write(22, 8'hA5); push_write(23, 8'hFC);
    push_write(24, 8'h00); push_write(25, 8'h3C); push_write(26, 8'hFF); push_write(27, 8'hFF);
    push_write(28, 8'hFF); push_write(29, 8'hFF); push_write(30, 8'hFF); push_write(31, 8'h00);
    push_start(16'd43);
    repeat (4) push_fetch();
    push_start(16'd44);
  endtask

  task automatic test_minute_limit();
    set_window(16, 48, 1);
    push_start(16'd43);
    push_fetch();
    push_fetch();
    push_start(16'd43);
    push_start(16'd43);
    push_fetch();
    set_window(16, 48, 0);
    push_start(16'd43);
    push_fetch();
  endtask

  task automatic test_window_faults();
    set_window(16, 48, 1440);
    push_start(16'd43);
    set_window(48, 16, 1440);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SPARE;
    cfg_wdata <= 17'h1FFFF;
    @(posedge clk);
    cfg_we <= 1'b0;
    push_fetch();
    push_start(16'd43);
    set_window(300, 300, 1440);
    push_start(16'($urandom));
    set_window(65535, 65536, 65535);
    run_session(2, 1'b0, 1'b1);
    set_window(0, 1, 1440);
    run_session(1, 1'b1, 1'b0);
  endtask

  // Hold the receiver off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    set_window(1000, 1064, 1440);
    tx_steady = 1'b1;
    rx_hold_left <= HOLD_CYCLES;
    repeat (12) push_write($urandom_range(0, 65535), 8'($urandom));
    run_session(3, 1'b1, 1'b1);
    tx_steady = 1'b0;
    wait_results();
  endtask

  task automatic test_random_traffic();
    int first_work;
    first_work = work_items;
    while (work_items - first_work < RANDOM_WORK) begin
      if ($urandom_range(0, 5) == 0) pick_window();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5:
          run_session($urandom_range(0, 6), 1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0);
        6, 7: begin
          push_start(16'($urandom));
          repeat ($urandom_range(0, 3)) push_fetch();
        end
        8: repeat ($urandom_range(1, 4)) push_write($urandom_range(0, 65535), 8'($urandom));
        default: begin
          if ($urandom_range(0, 1) != 0)
            push_op(OPN_SPARE, 16'($urandom), 8'($urandom), 16'($urandom));
          else
            push_fetch();
        end
      endcase
    end
  endtask

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    minute_result_t want;
    minute_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[38:0];
      if (expected_results.size() == 0) begin
        $error("status: expected no transaction, got 0x%0h", got.status);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 16'(want.status), 16'(got.status));
        check_field("pressure_tenths", 16'(want.pressure_tenths), 16'(got.pressure_tenths));
        check_field("apnea_count", 16'(want.apnea_count), 16'(got.apnea_count));
        check_field("hypopnea_count", 16'(want.hypopnea_count), 16'(got.hypopnea_count));
        check_field("snoring_count", 16'(want.snoring_count), 16'(got.snoring_count));
        check_field("minute_index", want.minute_index, got.minute_index);
      end
    end
  end

  // Receiver: stalls at random at a stall rate that is redrawn on rx_cycle; a requested hold-off overrides it
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_hold_left != 0) begin
      out_tready   <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      if (rx_cycle % 256 == 0) begin
        case ($urandom_range(0, 3))
          0: rx_stall_pct <= 0;
          1: rx_stall_pct <= 15;
          2: rx_stall_pct <= 50;
          default: rx_stall_pct <= 85;
        endcase
      end
      out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_image_extremes();
    test_idle_answers();
    test_marker_and_minutes();
    test_minute_limit();
    test_window_faults();
    test_backpressure();
    test_random_traffic();
    wait_results();
    if (error_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
